// ----- hdl/rgb2hsv_pkg.sv -----
// rgb2hsv_pkg: constants, stage layout, record types and division step helpers
// for the rgb to hsv converter; no dependencies
`default_nettype none

package rgb2hsv_pkg;

    // channel and field widths
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned PIXEL_W  = 3 * CHAN_W;
    localparam int unsigned HQUO_W   = 6;
    localparam int unsigned HNUM_W   = CHAN_W + HQUO_W;
    localparam int unsigned SNUM_W   = 2 * CHAN_W;
    localparam int unsigned DEG_W    = 9;
    localparam int unsigned HMUL_W   = 22;

    // hue arithmetic constants
    localparam int unsigned DEG_SIXTY   = 60;
    localparam int unsigned DEG_GREEN   = 120;
    localparam int unsigned DEG_BLUE    = 240;
    localparam int unsigned DEG_TURN    = 360;
    // deg*256/360 == (deg*HUE_RECIP) >> HUE_SHIFT for every deg below 360
    localparam int unsigned HUE_RECIP   = 11651;
    localparam int unsigned HUE_SHIFT   = 14;

    // hue sector codes
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    // pipeline stage layout
    localparam int unsigned DIV_STEPS  = CHAN_W;
    localparam int unsigned HUE_FIRST  = DIV_STEPS - HQUO_W;
    localparam int unsigned ST_IN      = 0;
    localparam int unsigned ST_SEL     = 1;
    localparam int unsigned ST_PREP    = 2;
    localparam int unsigned ST_DIV0    = 3;
    localparam int unsigned ST_DEG     = ST_DIV0 + DIV_STEPS;
    localparam int unsigned ST_MUL     = ST_DEG + 1;
    localparam int unsigned ST_OUT     = ST_MUL + 1;
    localparam int unsigned NUM_STAGES = ST_OUT + 1;

    // record carried through the selection stage
    typedef struct packed {
        logic [CHAN_W-1:0] bright;
        logic [CHAN_W-1:0] rng;
        logic [1:0]        sec;
        logic              neg;
        logic [CHAN_W-1:0] mag;
    } sel_t;

    // record carried through the divider stages
    typedef struct packed {
        logic [CHAN_W-1:0] bright;
        logic [CHAN_W-1:0] rng;
        logic [1:0]        sec;
        logic              neg;
        logic [CHAN_W-1:0] sat_rem;
        logic [CHAN_W-1:0] sat_low;
        logic [CHAN_W-1:0] sat_quo;
        logic [CHAN_W-1:0] hue_rem;
        logic [HQUO_W-1:0] hue_low;
        logic [HQUO_W-1:0] hue_quo;
    } div_t;

    // record after the hue angle is formed
    typedef struct packed {
        logic [DEG_W-1:0]  deg;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] bright;
    } deg_t;

    // record after the hue scaling product
    typedef struct packed {
        logic [HMUL_W-1:0] prod;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] bright;
    } mul_t;

    // one restoring division step on the saturation quotient, and on the hue
    // quotient when hue_on is set
    function automatic div_t div_step(input div_t d, input logic hue_on);
        logic [CHAN_W:0] s_trial;
        logic [CHAN_W:0] h_trial;
        logic            s_bit;
        logic            h_bit;
        div_t            o;
        o       = d;
        s_trial = {d.sat_rem, d.sat_low[CHAN_W-1]};
        s_bit   = (s_trial >= {1'b0, d.bright});
        o.sat_rem = s_bit ? CHAN_W'(s_trial - {1'b0, d.bright}) : s_trial[CHAN_W-1:0];
        o.sat_low = {d.sat_low[CHAN_W-2:0], 1'b0};
        o.sat_quo = {d.sat_quo[CHAN_W-2:0], s_bit};
        if (hue_on)
        begin
            h_trial = {d.hue_rem, d.hue_low[HQUO_W-1]};
            h_bit   = (h_trial >= {1'b0, d.rng});
            o.hue_rem = h_bit ? CHAN_W'(h_trial - {1'b0, d.rng}) : h_trial[CHAN_W-1:0];
            o.hue_low = {d.hue_low[HQUO_W-2:0], 1'b0};
            o.hue_quo = {d.hue_quo[HQUO_W-2:0], h_bit};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rgb_to_hsv_converter_top.sv -----
// rgb_to_hsv_converter_top: 8-bit rgb pixel to hue, saturation, brightness
// path: input, selection, dividend, divider, hue angle, scaling and output stages in order
// throughput: one item per cycle while the output is not stalled; two restoring dividers, one bit per stage
// stalls: each stage holds only while it is full and its successor is stalled
// reset: rst_n asynchronous active low, clears all stage valid bits
// depends on rgb2hsv_pkg
`default_nettype none

module rgb_to_hsv_converter_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  wire logic [rgb2hsv_pkg::PIXEL_W-1:0] s_axis_tdata,
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // hue [7:0], saturation [15:8], brightness [23:16]
    output      logic [rgb2hsv_pkg::PIXEL_W-1:0] m_axis_tdata
);
    import rgb2hsv_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] en;

    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;
    sel_t              sel_reg, sel_next;
    div_t              prep_reg, prep_next;
    div_t              div_reg  [DIV_STEPS];
    div_t              div_next [DIV_STEPS];
    deg_t              deg_reg, deg_next;
    mul_t              mul_reg, mul_next;
    logic [CHAN_W-1:0] hue_reg, sat_reg, bright_reg;

    // per-stage advance: a stage loads when empty or when its successor moves
    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[ST_IN];
    assign m_axis_tvalid = valid_reg[ST_OUT];
    assign m_axis_tdata  = {bright_reg, sat_reg, hue_reg};

    // valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[ST_IN])
            begin
                valid_reg[ST_IN] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            red_reg   <= s_axis_tdata[CHAN_W-1:0];
            green_reg <= s_axis_tdata[2*CHAN_W-1:CHAN_W];
            blue_reg  <= s_axis_tdata[3*CHAN_W-1:2*CHAN_W];
        end
    end

    // max, min, hue sector and signed channel difference
    always_comb
    begin
        logic [CHAN_W-1:0] lo;
        logic [CHAN_W-1:0] pa;
        logic [CHAN_W-1:0] pb;
        lo = (red_reg < green_reg) ? red_reg : green_reg;
        lo = (lo < blue_reg) ? lo : blue_reg;
        if (blue_reg >= red_reg && blue_reg >= green_reg)
        begin
            sel_next.sec    = SEC_BLUE;
            sel_next.bright = blue_reg;
            pa = red_reg;
            pb = green_reg;
        end
        else if (green_reg >= red_reg)
        begin
            sel_next.sec    = SEC_GREEN;
            sel_next.bright = green_reg;
            pa = blue_reg;
            pb = red_reg;
        end
        else
        begin
            sel_next.sec    = SEC_RED;
            sel_next.bright = red_reg;
            pa = green_reg;
            pb = blue_reg;
        end
        sel_next.rng = sel_next.bright - lo;
        sel_next.neg = (pa < pb);
        sel_next.mag = sel_next.neg ? (pb - pa) : (pa - pb);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SEL])
        begin
            sel_reg <= sel_next;
        end
    end

    // dividends: range*255 for saturation, 60*|difference| for hue
    always_comb
    begin
        logic [SNUM_W-1:0] s_num;
        logic [HNUM_W-1:0] h_num;
        s_num = {sel_reg.rng, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, sel_reg.rng};
        h_num = {{HQUO_W{1'b0}}, sel_reg.mag} * HNUM_W'(DEG_SIXTY);
        prep_next.bright  = sel_reg.bright;
        prep_next.rng     = sel_reg.rng;
        prep_next.sec     = sel_reg.sec;
        prep_next.neg     = sel_reg.neg;
        prep_next.sat_rem = s_num[SNUM_W-1:CHAN_W];
        prep_next.sat_low = s_num[CHAN_W-1:0];
        prep_next.sat_quo = '0;
        prep_next.hue_rem = h_num[HNUM_W-1:HQUO_W];
        prep_next.hue_low = h_num[HQUO_W-1:0];
        prep_next.hue_quo = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PREP])
        begin
            prep_reg <= prep_next;
        end
    end

    // divider stages, one quotient bit each; hue joins for its last six bits
    always_comb
    begin
        div_next[0] = div_step(prep_reg, 1'b0);
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            div_next[k] = div_step(div_reg[k-1], (k >= HUE_FIRST));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (en[ST_DIV0 + k])
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // hue angle in degrees with sector offset and wrap of negative angles
    always_comb
    begin
        div_t              d;
        logic [DEG_W-1:0]  q;
        logic [DEG_W-1:0]  base;
        d    = div_reg[DIV_STEPS-1];
        q    = {{(DEG_W-HQUO_W){1'b0}}, d.hue_quo};
        case (d.sec)
            SEC_BLUE:  base = DEG_W'(DEG_BLUE);
            SEC_GREEN: base = DEG_W'(DEG_GREEN);
            default:   base = '0;
        endcase
        if (d.rng == '0)
        begin
            deg_next.deg = '0;
        end
        else if (!d.neg)
        begin
            deg_next.deg = base + q;
        end
        else if (d.sec == SEC_RED)
        begin
            deg_next.deg = (q == '0) ? '0 : (DEG_W'(DEG_TURN) - q);
        end
        else
        begin
            deg_next.deg = base - q;
        end
        deg_next.sat    = (d.bright == '0) ? '0 : d.sat_quo;
        deg_next.bright = d.bright;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DEG])
        begin
            deg_reg <= deg_next;
        end
    end

    // hue scaling by reciprocal multiply
    always_comb
    begin
        mul_next.prod   = {{(HMUL_W-DEG_W){1'b0}}, deg_reg.deg} * HMUL_W'(HUE_RECIP);
        mul_next.sat    = deg_reg.sat;
        mul_next.bright = deg_reg.bright;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            mul_reg <= mul_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            hue_reg    <= mul_reg.prod[HUE_SHIFT+CHAN_W-1:HUE_SHIFT];
            sat_reg    <= mul_reg.sat;
            bright_reg <= mul_reg.bright;
        end
    end

`ifndef SYNTH
    // a full pipeline with a stalled output takes no new item
    assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !m_axis_tready) |-> !s_axis_tready)
        else $error("item accepted into a full stalled pipeline");

    // black pixel gives zero saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3*CHAN_W-1:2*CHAN_W] == '0)
            |-> (m_axis_tdata[2*CHAN_W-1:CHAN_W] == '0))
        else $error("nonzero saturation on a black pixel");

    // saturation remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_DEG-1] && div_reg[DIV_STEPS-1].bright != '0)
            |-> (div_reg[DIV_STEPS-1].sat_rem < div_reg[DIV_STEPS-1].bright))
        else $error("saturation divider remainder out of range");

    // hue quotient never exceeds sixty degrees for a coloured pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_DEG-1] && div_reg[DIV_STEPS-1].rng != '0)
            |-> (div_reg[DIV_STEPS-1].hue_quo <= HQUO_W'(DEG_SIXTY)))
        else $error("hue divider quotient out of range");

    // hue angle stays within one turn
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_MUL-1] |-> (deg_reg.deg < DEG_W'(DEG_TURN)))
        else $error("hue angle beyond a full turn");
`endif

endmodule

`default_nettype wire
